// ----- src/imvn_pkg.sv -----
package imvn_pkg;

  // field widths
  localparam int PIX_W = 8;
  localparam int TM_W  = 8;
  localparam int TV_W  = 16;
  localparam int CFG_DW = 16;

  // register reset values
  localparam logic [TM_W-1:0] TARGET_MEAN_RST = 8'd100;
  localparam logic [TV_W-1:0] TARGET_VAR_RST  = 16'd100;

  // statistics depth
  localparam int MAX_PIXELS_DEF = 1048576;

  // square root: digits of the root and its upper limit
  localparam int ROOT_BITS = 9;
  localparam int ROOT_CAP  = 256;
  localparam int PIX_MAX   = 255;

  // default multiplier widths for the default image size
  localparam int DEF_MW = 56;
  localparam int DEF_YW = 28;
  localparam int DEF_PW = 72;

  // digit counter width of the serial multiplier
  localparam int MUL_DIG_W = 5;

  typedef enum logic {
    OP_GATHER    = 1'b0,
    OP_NORMALIZE = 1'b1
  } op_t;

  typedef enum logic {
    CFG_TARGET_MEAN = 1'b0,
    CFG_TARGET_VAR  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NQ,
    ST_SS,
    ST_PN,
    ST_DD,
    ST_TDD,
    ST_ROOT,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_DIG_W-1:0] ndig;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

// ----- src/imvn_if.sv -----
interface imvn_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink (input valid, input opcode, input pixel, output ready);
endinterface

interface imvn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] normalized_pixel;
  logic       flat_image;
  logic       saturated;

  modport source (output valid, output normalized_pixel, output flat_image,
                  output saturated, input ready);
  modport sink (input valid, input normalized_pixel, input flat_image,
                input saturated, output ready);
endinterface

// ----- src/imvn_mul.sv -----
module imvn_mul import imvn_pkg::*; #(
  parameter int MW = DEF_MW,
  parameter int YW = DEF_YW,
  parameter int PW = DEF_PW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mul_ctl_t      ctl,
  input  logic [MW-1:0] m,
  input  logic [YW-1:0] y,
  output mul_sts_t      sts,
  output logic [PW-1:0] prod
);

  logic [PW-1:0]        acc_r;
  logic [MW-1:0]        m_r;
  logic [MW+1:0]        m3_r;
  logic [YW-1:0]        y_r;
  logic [MUL_DIG_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [PW-1:0]        sel;
  logic [PW-1:0]        acc_nxt;

  // radix-4 digit select, multiplier taken msb first
  always_comb begin
    case (y_r[YW-1 -: 2])
      2'd0:    sel = '0;
      2'd1:    sel = PW'(m_r);
      2'd2:    sel = PW'({m_r, 1'b0});
      2'd3:    sel = PW'(m3_r);
      default: sel = '0;
    endcase
    acc_nxt = (acc_r << 2) + sel;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.ndig;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MUL_DIG_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      acc_r <= '0;
      m_r   <= m;
      m3_r  <= {m, 1'b0} + (MW+2)'(m);
      y_r   <= y;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= y_r << 2;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

// ----- src/image_mean_variance_normalizer_core.sv -----
// channel   | dir | handshake      | payload
// in_chan   | in  | valid / ready  | opcode, pixel
// out_chan  | out | valid / ready  | normalized_pixel, flat_image, saturated
// cfg       | in  | cfg_we         | cfg_index, cfg_wdata
//
// a gather transaction leaves the core idle; a normalize transaction on a non-flat image
// runs through one shared radix-4 shift-add multiplier (p*N, D*D,
// target_variance*D^2) and a 9-step restoring square root;
// the first normalize of an image also forms N*Q - S*S once
// once that is formed, a flat image skips the multiplies and the root; reset is synchronous, active low
// a finished result waits in the output register while the next transaction enters;
// a stalled output only holds the next normalize at its last cycle
module image_mean_variance_normalizer_core import imvn_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  imvn_in_if.sink           in_chan,
  imvn_out_if.source        out_chan
);

  localparam int CW  = $clog2(64'(MAX_PIXELS) + 64'd1);
  localparam int SW  = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1);
  localparam int QW  = $clog2(64'(MAX_PIXELS) * 64'd65025 + 64'd1);
  localparam int VW  = CW + QW;
  localparam int TW  = 2 * SW + TV_W;
  localparam int MW  = (QW > 2 * SW) ? QW : 2 * SW;
  localparam int YW0 = (CW > SW) ? ((CW > TV_W) ? CW : TV_W) : ((SW > TV_W) ? SW : TV_W);
  localparam int YW  = YW0 + (YW0 % 2);
  localparam int PW  = (VW > TW) ? VW : TW;
  localparam int B_SH = 2 * (ROOT_BITS - 1);
  localparam int RW  = ((VW + B_SH > TW) ? VW + B_SH : TW) + 2;
  localparam int RCW = $clog2(ROOT_BITS);
  localparam int NQ_DIG  = (CW + 1) / 2;
  localparam int SS_DIG  = (SW + 1) / 2;
  localparam int PN_DIG  = PIX_W / 2;
  localparam int TDD_DIG = TV_W / 2;

  st_t state_r, state_nxt;

  logic [TM_W-1:0]  tm_r;
  logic [TV_W-1:0]  tv_r;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    sum_r;
  logic [QW-1:0]    sq_r;
  logic             phase_r;
  logic             v_valid_r;
  logic             flat_r;
  logic             op_run_r;
  logic             out_valid_r;

  logic [PIX_W-1:0] pix_r;
  logic [VW-1:0]    nq_r;
  logic [VW-1:0]    v_r;
  logic [SW-1:0]    d_r;
  logic             pos_r;
  logic [RW-1:0]    r_r;
  logic [RW-1:0]    a_r;
  logic [RW-1:0]    b_r;
  logic [ROOT_BITS-1:0] k_r;
  logic [RCW-1:0]   root_cnt_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_flat_r;
  logic             out_sat_r;

  mul_ctl_t         mul_ctl;
  mul_sts_t         mul_sts;
  logic [MW-1:0]    mul_m;
  logic [YW-1:0]    mul_y;
  logic [PW-1:0]    mul_prod;

  logic             in_acc;
  logic             in_rdy;
  logic             out_load;
  logic             flat_calc;
  logic [SW-1:0]    pn;
  logic             pn_pos;

  logic [RW-1:0]    inc;
  logic             take;

  logic [9:0]       kf, kc, kfc, kcc, pos_sum;
  logic [PIX_W-1:0] res_pix;
  logic             res_sat;

  assign in_acc   = in_chan.valid && in_rdy;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);
  assign flat_calc = PW'(nq_r) <= mul_prod;
  assign pn       = mul_prod[SW-1:0];
  assign pn_pos   = pn > sum_r;

  imvn_mul #(.MW(MW), .YW(YW), .PW(PW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .m     (mul_m),
    .y     (mul_y),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_chan.opcode == OP_NORMALIZE)) begin
          if (!v_valid_r) state_nxt = ST_NQ;
          else if (flat_r) state_nxt = ST_OUT;
          else state_nxt = ST_PN;
        end
      end
      ST_NQ:   if (mul_sts.done) state_nxt = ST_SS;
      ST_SS:   if (mul_sts.done) state_nxt = flat_calc ? ST_OUT : ST_PN;
      ST_PN:   if (mul_sts.done) state_nxt = ST_DD;
      ST_DD:   if (mul_sts.done) state_nxt = ST_TDD;
      ST_TDD:  if (mul_sts.done) state_nxt = ST_ROOT;
      ST_ROOT: if (root_cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: input ready and multiplier operands
  always_comb begin
    in_rdy        = 1'b0;
    mul_ctl.start = 1'b0;
    mul_ctl.ndig  = '0;
    mul_m         = '0;
    mul_y         = '0;
    case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_NQ: begin
        mul_ctl.start = !op_run_r;
        mul_ctl.ndig  = MUL_DIG_W'(NQ_DIG);
        mul_m         = MW'(sq_r);
        mul_y         = YW'(cnt_r) << (YW - 2 * NQ_DIG);
      end
      ST_SS: begin
        mul_ctl.start = !op_run_r;
        mul_ctl.ndig  = MUL_DIG_W'(SS_DIG);
        mul_m         = MW'(sum_r);
        mul_y         = YW'(sum_r) << (YW - 2 * SS_DIG);
      end
      ST_PN: begin
        mul_ctl.start = !op_run_r;
        mul_ctl.ndig  = MUL_DIG_W'(PN_DIG);
        mul_m         = MW'(cnt_r);
        mul_y         = YW'(pix_r) << (YW - 2 * PN_DIG);
      end
      ST_DD: begin
        mul_ctl.start = !op_run_r;
        mul_ctl.ndig  = MUL_DIG_W'(SS_DIG);
        mul_m         = MW'(d_r);
        mul_y         = YW'(d_r) << (YW - 2 * SS_DIG);
      end
      ST_TDD: begin
        mul_ctl.start = !op_run_r;
        mul_ctl.ndig  = MUL_DIG_W'(TDD_DIG);
        mul_m         = MW'(mul_prod[2*SW-1:0]);
        mul_y         = YW'(tv_r) << (YW - 2 * TDD_DIG);
      end
      default: in_rdy = 1'b0;
    endcase
  end

  // one restoring square root step: test the next root bit against the remainder
  always_comb begin
    inc  = a_r + b_r;
    take = inc <= r_r;
  end

  // final result: floor root upward, ceiling root downward, capped and clamped
  always_comb begin
    kf  = 10'(k_r);
    kc  = kf + 10'(r_r != '0);
    kfc = (kf > 10'(ROOT_CAP)) ? 10'(ROOT_CAP) : kf;
    kcc = (kc > 10'(ROOT_CAP)) ? 10'(ROOT_CAP) : kc;
    pos_sum = 10'(tm_r) + kfc;
    if (pos_r) begin
      res_sat = pos_sum > 10'(PIX_MAX);
      res_pix = res_sat ? PIX_W'(PIX_MAX) : pos_sum[PIX_W-1:0];
    end else begin
      res_sat = kcc > 10'(tm_r);
      res_pix = res_sat ? '0 : PIX_W'(10'(tm_r) - kcc);
    end
  end

  // control state, configuration and image statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tm_r        <= TARGET_MEAN_RST;
      tv_r        <= TARGET_VAR_RST;
      cnt_r       <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      phase_r     <= 1'b0;
      v_valid_r   <= 1'b0;
      flat_r      <= 1'b0;
      op_run_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_MEAN: tm_r <= cfg_wdata[TM_W-1:0];
          CFG_TARGET_VAR:  tv_r <= cfg_wdata[TV_W-1:0];
          default: ;
        endcase
      end

      // gather: a gather after normalizing starts a new image
      if (in_acc && (in_chan.opcode == OP_GATHER)) begin
        phase_r   <= 1'b0;
        v_valid_r <= 1'b0;
        if (phase_r) begin
          cnt_r <= CW'(1);
          sum_r <= SW'(in_chan.pixel);
          sq_r  <= QW'({8'd0, in_chan.pixel} * {8'd0, in_chan.pixel});
        end else if (cnt_r < CW'(MAX_PIXELS)) begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_r + SW'(in_chan.pixel);
          sq_r  <= sq_r + QW'({8'd0, in_chan.pixel} * {8'd0, in_chan.pixel});
        end
      end
      if (in_acc && (in_chan.opcode == OP_NORMALIZE)) phase_r <= 1'b1;

      // image variance is formed once per image
      if ((state_r == ST_SS) && mul_sts.done) begin
        v_valid_r <= 1'b1;
        flat_r    <= flat_calc;
      end

      if (mul_ctl.start) op_run_r <= 1'b1;
      else if (mul_sts.done) op_run_r <= 1'b0;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) pix_r <= in_chan.pixel;

    if ((state_r == ST_NQ) && mul_sts.done) nq_r <= mul_prod[VW-1:0];
    if ((state_r == ST_SS) && mul_sts.done) v_r <= VW'(PW'(nq_r) - mul_prod);

    // signed deviation of the pixel from the mean, scaled by N
    if ((state_r == ST_PN) && mul_sts.done) begin
      pos_r <= pn_pos;
      d_r   <= pn_pos ? pn - sum_r : sum_r - pn;
    end

    // root setup: remainder = target_variance * D^2, test term = V shifted for the top bit
    if ((state_r == ST_TDD) && mul_sts.done) begin
      r_r        <= RW'(mul_prod[TW-1:0]);
      a_r        <= '0;
      b_r        <= RW'(v_r) << B_SH;
      k_r        <= '0;
      root_cnt_r <= RCW'(ROOT_BITS - 1);
    end else if (state_r == ST_ROOT) begin
      r_r        <= take ? r_r - inc : r_r;
      a_r        <= take ? (a_r >> 1) + b_r : a_r >> 1;
      b_r        <= b_r >> 2;
      k_r        <= {k_r[ROOT_BITS-2:0], take};
      root_cnt_r <= root_cnt_r - 1'b1;
    end

    if (out_load) begin
      out_pix_r  <= flat_r ? tm_r : res_pix;
      out_flat_r <= flat_r;
      out_sat_r  <= flat_r ? 1'b0 : res_sat;
    end
  end

  assign in_chan.ready             = in_rdy;
  assign out_chan.valid            = out_valid_r;
  assign out_chan.normalized_pixel = out_pix_r;
  assign out_chan.flat_image       = out_flat_r;
  assign out_chan.saturated        = out_sat_r;

  // checks
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctl.start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == ST_NQ || state_r == ST_SS || state_r == ST_PN ||
                      state_r == ST_DD || state_r == ST_TDD))
    else $error("multiplier product arrived outside a multiply state");

  a_flat_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.flat_image) |-> !out_chan.saturated)
    else $error("flat result marked saturated");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PIXELS))
    else $error("pixel count above limit");

  a_phase_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_chan.opcode == OP_NORMALIZE)) |=> phase_r)
    else $error("normalize transaction did not enter normalize phase");

endmodule
